@@ rtl/hse_pkg.sv @@
// Shared constants, types and helpers for the Hermite spline evaluator.
// No dependencies; every file but hse_ram uses this package.
`default_nettype none
package hse_pkg;

  localparam int MAX_POINTS = 256;
  localparam int FRAC_BITS  = 16;

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int KEY_W  = 25;
  localparam int PC_W   = 9;
  localparam int T_W    = FRAC_BITS + 1;
  localparam int W_W    = FRAC_BITS + 5;
  localparam int PROD_W = 32 + W_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int DIFF_W = ((KEY_W > IDX_W + FRAC_BITS + 1) ? KEY_W : IDX_W + FRAC_BITS + 1) + 2;

  localparam logic [2:0] CMD_WR_LOC   = 3'd0;
  localparam logic [2:0] CMD_WR_ARR   = 3'd1;
  localparam logic [2:0] CMD_WR_LEV   = 3'd2;
  localparam logic [2:0] CMD_UPDATE   = 3'd3;
  localparam logic [2:0] CMD_EVAL_POS = 3'd4;
  localparam logic [2:0] CMD_EVAL_DER = 3'd5;

  localparam logic [1:0] MODE_AUTO   = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_USER   = 2'd2;

  localparam logic [T_W-1:0] ONE_T  = T_W'(1) << FRAC_BITS;
  localparam logic [31:0]    ONE_32 = 32'(1) << FRAC_BITS;

  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    logic           start;
    logic           deriv;
    logic [T_W-1:0] t;
  } basis_req_t;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [31:0] r;
    if (v > SAT_HI) r = 32'h7fff_ffff;
    else if (v < SAT_LO) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/hermite_spline_evaluator_core.sv @@
// Hermite spline evaluator: point tables in four RAMs, a sequencer, basis and MAC units.
// Depends on hse_pkg, hse_ram, hse_basis and hse_mac.
// One item at a time. Point and tangent writes go straight into the RAMs from idle. An
// evaluate makes two RAM reads, runs the basis unit (t^2, t^3, weights) and sends twelve
// products through the one shared multiply-accumulate unit; the block then returns to
// idle for the next item. With fewer than two points an evaluate takes its short-cut
// result, reading the location RAM only for the position of a single point. A tangent
// update walks the table with a sliding window through the single read port of the
// location RAM. A result waits in the output register while the next item is taken; a
// second result cannot leave until the first one has been taken.
`default_nettype none
module hermite_spline_evaluator_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_command,
  input  logic [7:0]         in_point_index,
  input  logic [1:0]         in_tangent_mode,
  input  logic signed [31:0] in_value_x,
  input  logic signed [31:0] in_value_y,
  input  logic signed [31:0] in_value_z,
  input  logic signed [24:0] in_curve_key,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import hse_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_UP0  = 10'b0000000010,
    S_UP1  = 10'b0000000100,
    S_UP2  = 10'b0000001000,
    S_UP3  = 10'b0000010000,
    S_EV_A = 10'b0000100000,
    S_EV_B = 10'b0001000000,
    S_EV_W = 10'b0010000000,
    S_MAC  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [PC_W-1:0] pc_r;
  logic            closed_r;
  logic [CNT_W-1:0] n;

  logic accept, cfg_wr;
  vec3_t in_vec;

  logic             loc_we, arr_we, lev_we, mode_we;
  logic [IDX_W-1:0] loc_waddr, arr_waddr, lev_waddr;
  vec3_t            arr_wdata, lev_wdata;
  logic [IDX_W-1:0] loc_raddr, arr_raddr, lev_raddr, mode_raddr;
  vec3_t            loc_rdata, arr_rdata, lev_rdata;
  logic [1:0]       mode_rdata;

  logic [IDX_W-1:0] a_r, b_r, i_r;
  logic [T_W-1:0]   t_r;
  logic             deriv_r, one_r, first_r;
  vec3_t            loc_a_r, lev_a_r, loc_b_r, arr_b_r, prev_r, cur_r, res_r;
  logic             out_valid_r;
  vec3_t            out_r;

  logic signed [DIFF_W-1:0] key_ext, seg_raw, seg_cl, nseg_ext, t_raw;
  logic [CNT_W-1:0] nseg;
  logic [IDX_W-1:0] a_c, b_c, ni;
  logic has_prev, has_next, last_pt, idx_ok;
  vec3_t up_arr, up_lev;

  basis_req_t breq;
  logic       bdone, mac_start, mac_done;
  logic [3:0][W_W-1:0] weights;
  vec3_t      mac_res;

  assign n      = (32'(pc_r) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : CNT_W'(pc_r);
  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign in_vec = {in_value_z, in_value_y, in_value_x};
  assign idx_ok = (32'(in_point_index) < MAX_POINTS);
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {31'd0, closed_r} : 32'(pc_r);

  // key to segment and fraction
  always_comb begin
    key_ext  = DIFF_W'(in_curve_key);
    seg_raw  = key_ext >>> FRAC_BITS;
    nseg     = closed_r ? n : n - CNT_W'(1);
    nseg_ext = $signed(DIFF_W'(nseg));
    if (seg_raw < 0) seg_cl = '0;
    else if (seg_raw > nseg_ext - 1) seg_cl = nseg_ext - DIFF_W'(1);
    else seg_cl = seg_raw;
    t_raw = key_ext - (seg_cl <<< FRAC_BITS);
    a_c   = seg_cl[IDX_W-1:0];
    b_c   = (CNT_W'(a_c) + CNT_W'(1) == n) ? '0 : a_c + IDX_W'(1);
  end

  // tangent update for point i_r: prev_r, cur_r and the next location from the RAM
  assign last_pt  = (CNT_W'(i_r) + CNT_W'(1) == n);
  assign ni       = last_pt ? '0 : i_r + IDX_W'(1);
  assign has_prev = closed_r || (i_r != '0);
  assign has_next = closed_r || !last_pt;

  always_comb begin
    logic signed [ACC_W-1:0] pv, cv, nv, half;
    logic [31:0] back, fwd, tg;
    up_arr = '0;
    up_lev = '0;
    for (int c = 0; c < 3; c++) begin
      pv   = ACC_W'($signed(prev_r[c]));
      cv   = ACC_W'($signed(cur_r[c]));
      nv   = ACC_W'($signed(loc_rdata[c]));
      back = sat32(cv - pv);
      fwd  = sat32(nv - cv);
      half = (nv - pv) >>> 1;
      if (has_prev && has_next) tg = half[31:0];
      else if (has_next) tg = fwd;
      else tg = back;
      case (mode_rdata)
        MODE_LINEAR: begin
          up_arr[c] = has_prev ? back : fwd;
          up_lev[c] = has_next ? fwd : back;
        end
        default: begin
          up_arr[c] = tg;
          up_lev[c] = tg;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt  = state_r;
    loc_we     = 1'b0;
    arr_we     = 1'b0;
    lev_we     = 1'b0;
    mode_we    = 1'b0;
    loc_waddr  = IDX_W'(in_point_index);
    arr_waddr  = IDX_W'(in_point_index);
    lev_waddr  = IDX_W'(in_point_index);
    arr_wdata  = in_vec;
    lev_wdata  = in_vec;
    loc_raddr  = b_r;
    arr_raddr  = b_r;
    lev_raddr  = a_r;
    mode_raddr = i_r;
    breq.start = 1'b0;
    breq.deriv = deriv_r;
    breq.t     = t_r;
    mac_start  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_WR_LOC: begin
              loc_we  = idx_ok;
              mode_we = idx_ok;
            end
            CMD_WR_ARR: arr_we = idx_ok;
            CMD_WR_LEV: lev_we = idx_ok;
            CMD_UPDATE: if (n >= CNT_W'(2)) state_nxt = S_UP0;
            CMD_EVAL_POS, CMD_EVAL_DER: begin
              if (n >= CNT_W'(2) || (in_command == CMD_EVAL_POS && n == CNT_W'(1)))
                state_nxt = S_EV_A;
              else
                state_nxt = S_DONE;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_UP0: begin
        loc_raddr = IDX_W'(n - CNT_W'(1));
        state_nxt = S_UP1;
      end
      S_UP1: begin
        loc_raddr = '0;
        state_nxt = S_UP2;
      end
      S_UP2: begin
        loc_raddr = ni;
        state_nxt = S_UP3;
      end
      S_UP3: begin
        arr_we    = (mode_rdata != MODE_USER);
        lev_we    = (mode_rdata != MODE_USER);
        arr_waddr = i_r;
        lev_waddr = i_r;
        arr_wdata = up_arr;
        lev_wdata = up_lev;
        state_nxt = last_pt ? S_IDLE : S_UP2;
      end
      S_EV_A: begin
        loc_raddr  = a_r;
        breq.start = !one_r;
        state_nxt  = S_EV_B;
      end
      S_EV_B: state_nxt = one_r ? S_DONE : S_EV_W;
      S_EV_W: begin
        if (bdone) begin
          mac_start = 1'b1;
          state_nxt = S_MAC;
        end
      end
      S_MAC: if (mac_done) state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      closed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        if (paddr[2]) closed_r <= pwdata[0];
        else pc_r <= pwdata[PC_W-1:0];
      end
      if (state_r == S_DONE && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && accept) begin
      deriv_r <= (in_command == CMD_EVAL_DER);
      one_r   <= (n < CNT_W'(2));
      a_r     <= (n < CNT_W'(2)) ? '0 : a_c;
      b_r     <= b_c;
      if (t_raw < 0) t_r <= '0;
      else if (t_raw > $signed(DIFF_W'(ONE_T))) t_r <= ONE_T;
      else t_r <= t_raw[T_W-1:0];
      // short-cut results when fewer than two points exist
      if (in_command == CMD_EVAL_DER) res_r <= {ONE_32, 32'd0, 32'd0};
      else res_r <= '0;
    end
    case (state_r)
      S_UP1: begin
        prev_r  <= loc_rdata;
        i_r     <= '0;
        first_r <= 1'b1;
      end
      S_UP2: if (first_r) cur_r <= loc_rdata;
      S_UP3: begin
        prev_r  <= cur_r;
        cur_r   <= loc_rdata;
        i_r     <= i_r + IDX_W'(1);
        first_r <= 1'b0;
      end
      S_EV_B: begin
        loc_a_r <= loc_rdata;
        lev_a_r <= lev_rdata;
        if (one_r) res_r <= loc_rdata;
      end
      S_EV_W: begin
        loc_b_r <= loc_rdata;
        arr_b_r <= arr_rdata;
      end
      S_MAC: if (mac_done) res_r <= mac_res;
      default: ;
    endcase
    if (state_r == S_DONE && (!out_valid_r || out_ready)) out_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_x     = $signed(out_r[0]);
  assign out_y     = $signed(out_r[1]);
  assign out_z     = $signed(out_r[2]);

  hse_ram #(.W(96), .D(MAX_POINTS)) u_loc (
    .clk(clk), .we(loc_we), .waddr(loc_waddr), .wdata(in_vec),
    .raddr(loc_raddr), .rdata(loc_rdata));
  hse_ram #(.W(96), .D(MAX_POINTS)) u_arr (
    .clk(clk), .we(arr_we), .waddr(arr_waddr), .wdata(arr_wdata),
    .raddr(arr_raddr), .rdata(arr_rdata));
  hse_ram #(.W(96), .D(MAX_POINTS)) u_lev (
    .clk(clk), .we(lev_we), .waddr(lev_waddr), .wdata(lev_wdata),
    .raddr(lev_raddr), .rdata(lev_rdata));
  hse_ram #(.W(2), .D(MAX_POINTS)) u_mode (
    .clk(clk), .we(mode_we), .waddr(loc_waddr), .wdata(in_tangent_mode),
    .raddr(mode_raddr), .rdata(mode_rdata));

  hse_basis u_basis (
    .clk(clk), .rst_n(rst_n), .req(breq), .done(bdone), .w(weights));

  hse_mac u_mac (
    .clk(clk), .rst_n(rst_n), .start(mac_start),
    .p0(loc_a_r), .m0(lev_a_r), .p1(loc_b_r), .m1(arr_b_r),
    .w(weights), .done(mac_done), .res(mac_res));
endmodule
`default_nettype wire

@@ rtl/hse_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package needed.
`default_nettype none
module hse_ram #(
  parameter int W = 32,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/hse_basis.sv @@
// Hermite basis weight unit: t^2, t^3, then the four position or derivative weights.
// Depends on hse_pkg.
`default_nettype none
module hse_basis (
  input  logic                clk,
  input  logic                rst_n,
  input  hse_pkg::basis_req_t req,
  output logic                done,
  output logic [3:0][hse_pkg::W_W-1:0] w
);
  import hse_pkg::*;

  logic [T_W-1:0] t_r, t2_r, t3_r;
  logic           deriv_r;
  logic [2:0]     stage_r;
  logic           done_r;
  logic [3:0][W_W-1:0] w_r, w_nxt;
  logic [2*T_W-1:0] sq;

  always_comb begin
    logic signed [W_W-1:0] ts, t2s, t3s, one;
    ts  = $signed(W_W'(t_r));
    t2s = $signed(W_W'(t2_r));
    t3s = $signed(W_W'(t3_r));
    one = $signed(W_W'(ONE_T));
    if (deriv_r) begin
      w_nxt[0] = W_W'(6 * t2s - 6 * ts);
      w_nxt[1] = W_W'(3 * t2s - 4 * ts + one);
      w_nxt[2] = W_W'(6 * ts - 6 * t2s);
      w_nxt[3] = W_W'(3 * t2s - 2 * ts);
    end else begin
      w_nxt[0] = W_W'(2 * t3s - 3 * t2s + one);
      w_nxt[1] = W_W'(t3s - 2 * t2s + ts);
      w_nxt[2] = W_W'(3 * t2s - 2 * t3s);
      w_nxt[3] = W_W'(t3s - t2s);
    end
  end

  // one shared multiplier: t*t for t^2, then t^2*t for t^3
  assign sq = stage_r[0] ? (2*T_W)'(t_r) * (2*T_W)'(t_r) : (2*T_W)'(t2_r) * (2*T_W)'(t_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
      done_r  <= 1'b0;
    end else begin
      stage_r <= {stage_r[1:0], req.start};
      done_r  <= stage_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      t_r     <= req.t;
      deriv_r <= req.deriv;
    end
    if (stage_r[0]) t2_r <= T_W'(sq >> FRAC_BITS);
    if (stage_r[1]) t3_r <= T_W'(sq >> FRAC_BITS);
    if (stage_r[2]) w_r <= w_nxt;
  end

  assign done = done_r;
  assign w    = w_r;
endmodule
`default_nettype wire

@@ rtl/hse_mac.sv @@
// Shared multiply-accumulate unit: twelve products, one per cycle, three saturated sums.
// Depends on hse_pkg.
`default_nettype none
module hse_mac (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  hse_pkg::vec3_t      p0,
  input  hse_pkg::vec3_t      m0,
  input  hse_pkg::vec3_t      p1,
  input  hse_pkg::vec3_t      m1,
  input  logic [3:0][hse_pkg::W_W-1:0] w,
  output logic                done,
  output hse_pkg::vec3_t      res
);
  import hse_pkg::*;

  logic [3:0] k_r, pk_r;
  logic       run_r, pv_r, done_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, sum;
  logic signed [31:0]       op;
  logic signed [W_W-1:0]    wt;
  vec3_t res_r;

  always_comb begin
    case (k_r[1:0])
      2'd0:    op = $signed(p0[k_r[3:2]]);
      2'd1:    op = $signed(m0[k_r[3:2]]);
      2'd2:    op = $signed(p1[k_r[3:2]]);
      default: op = $signed(m1[k_r[3:2]]);
    endcase
    wt  = $signed(w[k_r[1:0]]);
    sum = (pk_r[1:0] == 2'd0) ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= pv_r && (pk_r == 4'd11);
      pv_r   <= run_r;
      if (start) begin
        run_r <= 1'b1;
        k_r   <= '0;
      end else if (run_r) begin
        k_r <= k_r + 4'd1;
        if (k_r == 4'd11) run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run_r) begin
      prod_r <= PROD_W'(op) * PROD_W'(wt);
      pk_r   <= k_r;
    end
    if (pv_r) begin
      acc_r <= sum;
      if (pk_r[1:0] == 2'd3) res_r[pk_r[3:2]] <= sat32(sum >>> FRAC_BITS);
    end
  end

  assign done = done_r;
  assign res  = res_r;
endmodule
`default_nettype wire

@@ rtl/hse_checker.sv @@
// Port-level checks for the Hermite spline evaluator, bound to the top level.
// Depends on hse_pkg and the top level's ports.
`default_nettype none
module hse_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [2:0]         in_command,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_x,
  input logic signed [31:0] out_y,
  input logic signed [31:0] out_z,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [2:0]         paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata
);
  import hse_pkg::*;

  // a waiting result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z))
    else $error("result item changed while stalled");

  // a write or update item never produces a result
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_command[2] && !out_valid |=> !out_valid)
    else $error("result from a non-evaluate item");

  // an evaluate item takes the block out of the idle state
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == CMD_EVAL_POS || in_command == CMD_EVAL_DER)
    |=> !in_ready)
    else $error("evaluate item did not occupy the block");

  // point count reads back what was written
  a_cfg_rb: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && !paddr[2] |=> paddr[2] || prdata[8:0] == $past(pwdata[8:0]))
    else $error("point count read-back mismatch");
endmodule

bind hermite_spline_evaluator_core hse_checker u_hse_checker (.*);
`default_nettype wire

@@ tb/hermite_spline_evaluator_core_tb.sv @@
// Testbench for hermite_spline_evaluator_core: directed and random command traffic,
// checked against a behavioral spline predictor. Depends on hse_pkg and the RTL only.
module hermite_spline_evaluator_core_tb;

  localparam logic [2:0] CMD_WR_LOC   = hse_pkg::CMD_WR_LOC;
  localparam logic [2:0] CMD_WR_ARR   = hse_pkg::CMD_WR_ARR;
  localparam logic [2:0] CMD_WR_LEV   = hse_pkg::CMD_WR_LEV;
  localparam logic [2:0] CMD_UPDATE   = hse_pkg::CMD_UPDATE;
  localparam logic [2:0] CMD_EVAL_POS = hse_pkg::CMD_EVAL_POS;
  localparam logic [2:0] CMD_EVAL_DER = hse_pkg::CMD_EVAL_DER;
  localparam logic [2:0] CMD_SPARE6   = 3'd6;
  localparam logic [2:0] CMD_SPARE7   = 3'd7;
  localparam logic [1:0] MODE_AUTO    = hse_pkg::MODE_AUTO;
  localparam logic [1:0] MODE_LINEAR  = hse_pkg::MODE_LINEAR;
  localparam logic [1:0] MODE_USER    = hse_pkg::MODE_USER;
  localparam logic [1:0] MODE_SPARE   = 2'd3;
  localparam logic [2:0] REG_POINT_COUNT = 3'd0;
  localparam logic [2:0] REG_CLOSED_LOOP = 3'd4;
  localparam int NPTS      = hse_pkg::MAX_POINTS;
  localparam int FB        = hse_pkg::FRAC_BITS;
  localparam longint ONE   = 64'sd1 <<< FB;
  localparam int SETTLE    = 700;
  localparam int ITEM_GOAL = 1450;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [31:0] x, y, z;
  } coord_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_command = '0;
  logic [7:0] in_point_index = '0;
  logic [1:0] in_tangent_mode = '0;
  logic signed [31:0] in_value_x = '0, in_value_y = '0, in_value_z = '0;
  logic signed [24:0] in_curve_key = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  hermite_spline_evaluator_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_point_index(in_point_index),
    .in_tangent_mode(in_tangent_mode),
    .in_value_x(in_value_x), .in_value_y(in_value_y), .in_value_z(in_value_z),
    .in_curve_key(in_curve_key),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  int loc_mem[NPTS][3];
  int arr_mem[NPTS][3];
  int lev_mem[NPTS][3];
  logic [1:0] mode_mem[NPTS];
  bit loc_set[NPTS], arr_set[NPTS], lev_set[NPTS];
  int unsigned point_count_reg = 0;
  bit closed_reg = 0;

  coord_t expected_points[$];
  int errors = 0;
  int items_sent = 0;
  bit no_gaps = 0;
  longint cycles = 0;
  int ready_hold = 0;

  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic int active_points();
    return (point_count_reg > NPTS) ? NPTS : point_count_reg;
  endfunction

  function automatic void derive_tangents();
    int n;
    bit hp, hn;
    int pi, ni, tg, back, fwd;
    longint cur, prv, nxt;
    n = active_points();
    if (n < 2) return;
    for (int i = 0; i < n; i++) begin
      if (mode_mem[i] == MODE_USER) continue;
      hp = closed_reg || i > 0;
      hn = closed_reg || i < n - 1;
      pi = (i + n - 1) % n;
      ni = (i + 1) % n;
      for (int c = 0; c < 3; c++) begin
        prv = loc_mem[pi][c];
        nxt = loc_mem[ni][c];
        cur = loc_mem[i][c];
        back = clamp32(cur - prv);
        fwd = clamp32(nxt - cur);
        if (mode_mem[i] == MODE_LINEAR) begin
          arr_mem[i][c] = hp ? back : fwd;
          lev_mem[i][c] = hn ? fwd : back;
        end else begin
          if (hp && hn) tg = clamp32((nxt - prv) >>> 1);
          else if (hn) tg = fwd;
          else tg = back;
          arr_mem[i][c] = tg;
          lev_mem[i][c] = tg;
        end
      end
      arr_set[i] = 1;
      lev_set[i] = 1;
    end
  endfunction

  function automatic coord_t spline_point(logic signed [24:0] key, bit deriv);
    coord_t r;
    int n, a, b;
    longint nseg, seg, t, t2, t3, w0, w1, w2, w3, acc;
    int res[3];
    n = active_points();
    if (n < 2) begin
      r.x = 0; r.y = 0; r.z = 0;
      if (deriv) r.z = 32'(ONE);
      else if (n == 1) begin
        r.x = loc_mem[0][0]; r.y = loc_mem[0][1]; r.z = loc_mem[0][2];
      end
      return r;
    end
    nseg = closed_reg ? n : n - 1;
    seg = longint'(key) >>> FB;
    if (seg < 0) seg = 0;
    if (seg > nseg - 1) seg = nseg - 1;
    t = longint'(key) - seg * ONE;
    if (t < 0) t = 0;
    if (t > ONE) t = ONE;
    t2 = (t * t) >>> FB;
    t3 = (t2 * t) >>> FB;
    if (deriv) begin
      w0 = 6 * t2 - 6 * t;
      w1 = 3 * t2 - 4 * t + ONE;
      w2 = -6 * t2 + 6 * t;
      w3 = 3 * t2 - 2 * t;
    end else begin
      w0 = 2 * t3 - 3 * t2 + ONE;
      w1 = t3 - 2 * t2 + t;
      w2 = -2 * t3 + 3 * t2;
      w3 = t3 - t2;
    end
    a = int'(seg);
    b = (a + 1) % n;
    for (int c = 0; c < 3; c++) begin
      acc = longint'(loc_mem[a][c]) * w0 + longint'(lev_mem[a][c]) * w1
          + longint'(loc_mem[b][c]) * w2 + longint'(arr_mem[b][c]) * w3;
      res[c] = clamp32(acc >>> FB);
    end
    r.x = res[0]; r.y = res[1]; r.z = res[2];
    return r;
  endfunction

  function automatic void apply_command(logic [2:0] cmd, logic [7:0] idx, logic [1:0] mode,
                                        int vx, int vy, int vz, logic signed [24:0] key);
    case (cmd)
      CMD_WR_LOC: begin
        loc_mem[idx] = '{vx, vy, vz};
        mode_mem[idx] = mode;
        loc_set[idx] = 1;
      end
      CMD_WR_ARR: begin
        arr_mem[idx] = '{vx, vy, vz};
        arr_set[idx] = 1;
      end
      CMD_WR_LEV: begin
        lev_mem[idx] = '{vx, vy, vz};
        lev_set[idx] = 1;
      end
      CMD_UPDATE: derive_tangents();
      CMD_EVAL_POS: expected_points = {expected_points, spline_point(key, 1'b0)};
      CMD_EVAL_DER: expected_points = {expected_points, spline_point(key, 1'b1)};
      default: ;
    endcase
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 0;
      3, 4: return $urandom;
      default: return $urandom_range(0, 32'h00ffffff) - 32'h00800000;
    endcase
  endfunction

  task automatic send_item(logic [2:0] cmd, logic [7:0] idx, logic [1:0] mode,
                           int vx, int vy, int vz, logic signed [24:0] key);
    int gap;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_point_index <= idx;
    in_tangent_mode <= mode;
    in_value_x <= vx;
    in_value_y <= vy;
    in_value_z <= vz;
    in_curve_key <= key;
    do @(posedge clk); while (!in_ready);
    apply_command(cmd, idx, mode, vx, vy, vz, key);
    items_sent++;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic eval_item(bit deriv, logic signed [24:0] key);
    send_item(deriv ? CMD_EVAL_DER : CMD_EVAL_POS, $urandom, $urandom, $urandom, $urandom,
              $urandom, key);
  endtask

  // wait for all results, then let a tangent pass over a full table run out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == REG_POINT_COUNT) point_count_reg = data[8:0];
    else closed_reg = data[0];
  endtask

  // make every entry that an update or evaluate can read defined
  task automatic fill_points(int n);
    for (int i = 0; i < n && i < NPTS; i++) begin
      if (!loc_set[i])
        send_item(CMD_WR_LOC, i, $urandom, rand_coord(), rand_coord(), rand_coord(), $urandom);
      if (!arr_set[i])
        send_item(CMD_WR_ARR, i, $urandom, rand_coord(), rand_coord(), rand_coord(), $urandom);
      if (!lev_set[i])
        send_item(CMD_WR_LEV, i, $urandom, rand_coord(), rand_coord(), rand_coord(), $urandom);
    end
  endtask

  task automatic test_empty_table();
    eval_item(0, 25'sd0);
    eval_item(1, 25'sd65536);
    send_item(CMD_UPDATE, 0, 0, 0, 0, 0, 0);
    send_item(CMD_SPARE6, 8'hff, 2'd3, -1, -1, -1, -1);
    send_item(CMD_SPARE7, 8'hff, 2'd3, -1, -1, -1, -1);
    drain();
  endtask

  task automatic test_single_point();
    cfg_write(REG_POINT_COUNT, 1);
    send_item(CMD_WR_LOC, 0, MODE_AUTO, 32'h7fffffff, 32'h80000000, 32'h00012345, 0);
    eval_item(0, 25'sd98304);
    eval_item(1, 25'sd0);
    drain();
  endtask

  task automatic test_open_curve();
    cfg_write(REG_POINT_COUNT, 4);
    cfg_write(REG_CLOSED_LOOP, 0);
    send_item(CMD_WR_LOC, 0, MODE_AUTO, 32'h7fffffff, 32'h80000000, 0, 0);
    send_item(CMD_WR_LOC, 1, MODE_LINEAR, 32'h80000000, 32'h7fffffff, 32'h00010000, 0);
    send_item(CMD_WR_LOC, 2, MODE_USER, 32'h00030000, -32'sd65536, 32'h7fffffff, 0);
    send_item(CMD_WR_LOC, 3, MODE_SPARE, -32'sd1, 32'h00028000, 32'h80000000, 0);
    send_item(CMD_WR_ARR, 2, 0, 32'h80000000, 32'h7fffffff, 32'h00004000, 0);
    send_item(CMD_WR_LEV, 2, 0, 32'h7fffffff, 32'h80000000, -32'sd16384, 0);
    send_item(CMD_UPDATE, 0, 0, 0, 0, 0, 0);
    eval_item(0, -25'sd16777216);
    eval_item(1, 25'sd16777215);
    eval_item(0, 25'sd65536 + 25'sd32768);
    eval_item(1, 25'sd131072 + 25'sd1);
    eval_item(0, 25'sd196608);
    drain();
  endtask

  task automatic test_closed_loop();
    cfg_write(REG_CLOSED_LOOP, 1);
    send_item(CMD_UPDATE, 0, 0, 0, 0, 0, 0);
    eval_item(0, 25'sd229376);
    eval_item(1, 25'sd16777215);
    drain();
  endtask

  task automatic test_random_traffic();
    int n, ops, nseg, r;
    logic signed [24:0] key;
    while (items_sent < ITEM_GOAL) begin
      r = $urandom_range(0, 99);
      if (r < 65) n = $urandom_range(2, 8);
      else if (r < 72) n = $urandom_range(0, 1);
      else if (r < 90) n = $urandom_range(9, 40);
      else if (r < 95) n = 256;
      else n = $urandom_range(257, 511);
      cfg_write(REG_POINT_COUNT, n);
      cfg_write(REG_CLOSED_LOOP, $urandom_range(0, 1));
      no_gaps = ($urandom_range(0, 3) == 0);
      fill_points(n);
      if (n > NPTS) n = NPTS;
      ops = $urandom_range(10, 40);
      repeat (ops) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          // writes may also land on points beyond the active count
          send_item(CMD_WR_LOC, (n > 0 && r < 9) ? $urandom_range(0, n - 1) : $urandom,
                    $urandom, rand_coord(), rand_coord(), rand_coord(), $urandom);
        end else if (r < 22) begin
          send_item((r < 17) ? CMD_WR_ARR : CMD_WR_LEV,
                    (n > 0) ? $urandom_range(0, n - 1) : $urandom, $urandom,
                    rand_coord(), rand_coord(), rand_coord(), $urandom);
        end else if (r < 32) begin
          send_item(CMD_UPDATE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else if (r < 34) begin
          send_item((r == 32) ? CMD_SPARE6 : CMD_SPARE7, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom);
        end else begin
          nseg = (n < 2) ? 1 : (closed_reg ? n : n - 1);
          if ($urandom_range(0, 9) < 6)
            key = ($urandom_range(0, nseg + 1) - 1) * 65536 + $urandom_range(0, 65535);
          else
            key = $urandom;
          eval_item($urandom_range(0, 1), key);
        end
      end
      drain();
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[hermite_spline_evaluator_core] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      ready_hold = gap_len();
    end
  end

  always @(posedge clk) begin
    coord_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result %h %h %h", out_x, out_y, out_z);
      end else begin
        want = expected_points.pop_front();
        if (out_x !== want.x || out_y !== want.y || out_z !== want.z) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %h %h %h, got %h %h %h",
                     want.x, want.y, want.z, out_x, out_y, out_z);
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_single_point();
    test_open_curve();
    test_closed_loop();
    test_random_traffic();
    if (expected_points.size() != 0) errors++;
    if (errors == 0) begin
      $display("[hermite_spline_evaluator_core] OK");
    end else begin
      $display("[hermite_spline_evaluator_core] ERROR");
    end
    $finish;
  end

endmodule
